// File: rtl/hfci_pkg.sv
`default_nettype none
// Types and constants shared by the heightfield cell interpolator.
package hfci_pkg;

  localparam int unsigned CellsPerSide = 8;
  localparam int unsigned GridStride   = 2 * CellsPerSide + 1;
  localparam int unsigned GridRows     = CellsPerSide + 1;
  localparam int unsigned GridDepth    = GridRows * GridRows + CellsPerSide * CellsPerSide;

  localparam int unsigned HeightW    = 24;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned CellFieldW = 3;
  localparam int unsigned FracW      = 12;

  localparam int unsigned CellW    = $clog2(CellsPerSide);
  localparam int unsigned RowAddrW = $clog2(GridRows);
  localparam int unsigned LaneW    = $clog2(GridStride);
  localparam int unsigned WordW    = GridStride * HeightW;

  localparam int unsigned WeightW = FracW + 3;
  localparam int unsigned ProdW   = HeightW + WeightW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned RoundW  = SumW - FracW;

  localparam int unsigned FracOne  = 1 << FracW;
  localparam int unsigned FracHalf = 1 << (FracW - 1);
  localparam int          HeightMax = (1 << (HeightW - 1)) - 1;
  localparam int          HeightMin = -(1 << (HeightW - 1));

  // Reciprocal for splitting a grid index into row and lane.
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipMul   = (1 << RecipShift) / GridStride;
  localparam int unsigned RecipW     = $clog2(RecipMul + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One grid row: corner heights in the low lanes, cell-center heights above.
  typedef logic [GridStride-1:0][HeightW-1:0] grid_row_t;

  typedef struct packed {
    op_e                       op;
    logic [IndexW-1:0]         write_index;
    logic signed [HeightW-1:0] write_value;
    logic [CellFieldW-1:0]     patch_row;
    logic [CellFieldW-1:0]     patch_col;
    logic [FracW-1:0]          frac_row;
    logic [FracW-1:0]          frac_col;
  } hfci_in_t;

  typedef struct packed {
    logic                      found;
    logic signed [HeightW-1:0] height_out;
  } hfci_out_t;

endpackage
`default_nettype wire

// File: rtl/hfci_ram.sv
`default_nettype none
// Generic synchronous RAM: one write port, two registered read ports.
module hfci_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

// File: rtl/heightfield_cell_interpolate_top.sv
`default_nettype none
// Heightfield cell interpolator: grid row memory and barycentric height pipeline.
//
//   Channel | Direction | Word type            | Handshake
//   in      | input     | hfci_pkg::hfci_in_t  | in_valid_i  / in_ready_o
//   out     | output    | hfci_pkg::hfci_out_t | out_valid_o / out_ready_i
//
// One input word per cycle while in_ready_o is high. A query's grid rows are read at
// accept, then triangle and weight select, multiply, sum and round are registered in turn.
// A write gives no output word; it reads, patches and writes back one grid row
// in the cycle after accept, and that row is forwarded to the next reader.
// Reset clears the stage and forwarding valid bits only; the grid memory is not cleared.
// Each stage holds only while the stage after it is full, so input is taken
// while a result waits until all five stages are occupied.
module heightfield_cell_interpolate_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hfci_pkg::hfci_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hfci_pkg::hfci_out_t out_data_o
);

  localparam int unsigned IndexW   = hfci_pkg::IndexW;
  localparam int unsigned RecipW   = hfci_pkg::RecipW;
  localparam int unsigned RowAddrW = hfci_pkg::RowAddrW;
  localparam int unsigned LaneW    = hfci_pkg::LaneW;
  localparam int unsigned CellW    = hfci_pkg::CellW;
  localparam int unsigned HeightW  = hfci_pkg::HeightW;
  localparam int unsigned FracW    = hfci_pkg::FracW;
  localparam int unsigned WeightW  = hfci_pkg::WeightW;
  localparam int unsigned ProdW    = hfci_pkg::ProdW;
  localparam int unsigned SumW     = hfci_pkg::SumW;
  localparam int unsigned RoundW   = hfci_pkg::RoundW;

  // ---------------------------------------------------------------- handshake
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_wr_q;
  logic take_out, take_4, take_3, take_2;
  logic move_1, move_1q, move_2, move_3, move_4;
  logic accept, s1_load;

  assign take_out = !out_v_q || out_ready_i;
  assign take_4   = !s4_v_q || take_out;
  assign take_3   = !s3_v_q || take_4;
  assign take_2   = !s2_v_q || take_3;
  assign move_4   = s4_v_q && take_out;
  assign move_3   = s3_v_q && take_4;
  assign move_2   = s2_v_q && take_3;
  assign move_1q  = s1_v_q && !s1_wr_q && take_2;
  // A write leaves stage 1 unconditionally: its only effect is the memory write.
  assign move_1   = s1_v_q && (s1_wr_q || take_2);

  assign in_ready_o = !s1_v_q || move_1;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------- index decode
  logic [IndexW+RecipW-1:0] dec_prod;
  logic [IndexW-1:0]        dec_q, dec_rem, dec_row, dec_lane;
  logic                     dec_valid;

  assign dec_prod = (IndexW+RecipW)'(in_data_i.write_index)
                  * (IndexW+RecipW)'(hfci_pkg::RecipMul);
  assign dec_q    = IndexW'(dec_prod >> hfci_pkg::RecipShift);
  assign dec_rem  = in_data_i.write_index - IndexW'(dec_q * IndexW'(hfci_pkg::GridStride));

  // Reciprocal underestimates the row by at most one; correct once.
  always_comb begin
    if (32'(dec_rem) >= hfci_pkg::GridStride) begin
      dec_row  = dec_q + IndexW'(1);
      dec_lane = dec_rem - IndexW'(hfci_pkg::GridStride);
    end else begin
      dec_row  = dec_q;
      dec_lane = dec_rem;
    end
  end

  assign dec_valid = 32'(in_data_i.write_index) < hfci_pkg::GridDepth;

  // ---------------------------------------------------------- query address
  logic [CellW-1:0]    q_row, q_col;
  logic [RowAddrW-1:0] rd_addr_a, rd_addr_b;

  assign q_row = (32'(in_data_i.patch_row) >= hfci_pkg::CellsPerSide)
               ? CellW'(hfci_pkg::CellsPerSide - 1) : CellW'(in_data_i.patch_row);
  assign q_col = (32'(in_data_i.patch_col) >= hfci_pkg::CellsPerSide)
               ? CellW'(hfci_pkg::CellsPerSide - 1) : CellW'(in_data_i.patch_col);

  assign rd_addr_a = (in_data_i.op == hfci_pkg::OP_WRITE) ? RowAddrW'(dec_row)
                                                          : RowAddrW'(q_row);
  assign rd_addr_b = RowAddrW'(q_row) + RowAddrW'(1);

  // Out-of-range writes are dropped here.
  assign s1_load = accept && ((in_data_i.op == hfci_pkg::OP_QUERY) || dec_valid);

  // ---------------------------------------------------------- grid memory
  logic                      ram_we;
  logic [hfci_pkg::WordW-1:0] ram_rdata_a, ram_rdata_b;
  hfci_pkg::grid_row_t       row_a, row_b, row_merged;

  logic [RowAddrW-1:0] s1_row_q, s1_row_b;
  logic [LaneW-1:0]    s1_lane_q;
  logic [HeightW-1:0]  s1_wval_q;
  logic [CellW-1:0]    s1_col_q;
  logic [FracW-1:0]    s1_fr_q, s1_fc_q;

  logic                fwd_v_q;
  logic [RowAddrW-1:0] fwd_row_q;
  hfci_pkg::grid_row_t fwd_word_q;

  assign ram_we = s1_v_q && s1_wr_q;

  hfci_ram #(
    .Width (hfci_pkg::WordW),
    .Depth (hfci_pkg::GridRows)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s1_row_q),
    .wdata_i   (row_merged),
    .re_i      (s1_load),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // The row written back at the accept edge is missed by that read; forward it.
  assign s1_row_b = s1_row_q + RowAddrW'(1);
  assign row_a = (fwd_v_q && (fwd_row_q == s1_row_q)) ? fwd_word_q
                                                      : hfci_pkg::grid_row_t'(ram_rdata_a);
  assign row_b = (fwd_v_q && (fwd_row_q == s1_row_b)) ? fwd_word_q
                                                      : hfci_pkg::grid_row_t'(ram_rdata_b);

  always_comb begin
    row_merged             = row_a;
    row_merged[s1_lane_q]  = s1_wval_q;
  end

  // ---------------------------------------------------------- stage 1 select
  logic [LaneW-1:0]          col_l;
  logic signed [HeightW-1:0] h_c, h_tl, h_tr, h_bl, h_br;

  assign col_l = LaneW'(s1_col_q);
  assign h_tl  = row_a[col_l];
  assign h_tr  = row_a[col_l + LaneW'(1)];
  assign h_c   = row_a[col_l + LaneW'(hfci_pkg::CellsPerSide + 1)];
  assign h_bl  = row_b[col_l];
  assign h_br  = row_b[col_l + LaneW'(1)];

  // Weights over a common denominator of FracOne; x runs along rows, y along columns.
  logic signed [WeightW-1:0] wx, wy, w_one;
  logic signed [WeightW-1:0] t_sxy, t_omxy, t_xmy, t_ymx, t_2x, t_2y, t_2omx, t_2omy;
  logic                      pass1, pass2, pass3, pass4;

  assign wx     = signed'(WeightW'(s1_fr_q));
  assign wy     = signed'(WeightW'(s1_fc_q));
  assign w_one  = signed'(WeightW'(hfci_pkg::FracOne));
  assign t_sxy  = wx + wy - w_one;
  assign t_omxy = w_one - wx - wy;
  assign t_xmy  = wx - wy;
  assign t_ymx  = wy - wx;
  assign t_2x   = wx <<< 1;
  assign t_2y   = wy <<< 1;
  assign t_2omx = (w_one - wx) <<< 1;
  assign t_2omy = (w_one - wy) <<< 1;

  // Triangles in test order: (C,TL,BL), (C,TR,TL), (C,BR,TR), (C,BL,BR).
  assign pass1 = !t_2y[WeightW-1]   && !t_omxy[WeightW-1] && !t_xmy[WeightW-1];
  assign pass2 = !t_2x[WeightW-1]   && !t_ymx[WeightW-1]  && !t_omxy[WeightW-1];
  assign pass3 = !t_2omy[WeightW-1] && !t_sxy[WeightW-1]  && !t_ymx[WeightW-1];
  assign pass4 = !t_2omx[WeightW-1] && !t_xmy[WeightW-1]  && !t_sxy[WeightW-1];

  logic                      s1_found;
  logic signed [HeightW-1:0] s1_hb, s1_hc;
  logic signed [WeightW-1:0] s1_wa, s1_wb, s1_wc;

  always_comb begin
    s1_found = 1'b1;
    s1_hb    = h_tl;
    s1_hc    = h_bl;
    s1_wa    = t_2y;
    s1_wb    = t_omxy;
    s1_wc    = t_xmy;
    if (!pass1) begin
      if (pass2) begin
        s1_hb = h_tr;
        s1_hc = h_tl;
        s1_wa = t_2x;
        s1_wb = t_ymx;
        s1_wc = t_omxy;
      end else if (pass3) begin
        s1_hb = h_br;
        s1_hc = h_tr;
        s1_wa = t_2omy;
        s1_wb = t_sxy;
        s1_wc = t_ymx;
      end else if (pass4) begin
        s1_hb = h_bl;
        s1_hc = h_br;
        s1_wa = t_2omx;
        s1_wb = t_xmy;
        s1_wc = t_sxy;
      end else begin
        // zero weights give a zero height
        s1_found = 1'b0;
        s1_wa    = '0;
        s1_wb    = '0;
        s1_wc    = '0;
      end
    end
  end

  // ---------------------------------------------------------- later stages
  logic                      s2_found_q, s3_found_q, s4_found_q;
  logic signed [HeightW-1:0] s2_ha_q, s2_hb_q, s2_hc_q;
  logic signed [WeightW-1:0] s2_wa_q, s2_wb_q, s2_wc_q;
  logic signed [ProdW-1:0]   s3_pa_d, s3_pb_d, s3_pc_d;
  logic signed [ProdW-1:0]   s3_pa_q, s3_pb_q, s3_pc_q;
  logic signed [SumW-1:0]    s4_sum_d, s4_sum_q;

  assign s3_pa_d  = ProdW'(s2_ha_q) * ProdW'(s2_wa_q);
  assign s3_pb_d  = ProdW'(s2_hb_q) * ProdW'(s2_wb_q);
  assign s3_pc_d  = ProdW'(s2_hc_q) * ProdW'(s2_wc_q);
  assign s4_sum_d = SumW'(s3_pa_q) + SumW'(s3_pb_q) + SumW'(s3_pc_q);

  // Round half away from zero: floor((sum + half - neg) / FracOne).
  logic signed [SumW-1:0]    rnd_bias, rnd_sum;
  logic signed [RoundW-1:0]  rnd_q;
  logic signed [HeightW-1:0] height_d;
  hfci_pkg::hfci_out_t       out_data_d, out_data_q;

  assign rnd_bias = s4_sum_q[SumW-1] ? signed'(SumW'(hfci_pkg::FracHalf - 1))
                                     : signed'(SumW'(hfci_pkg::FracHalf));
  assign rnd_sum  = s4_sum_q + rnd_bias;
  assign rnd_q    = signed'(rnd_sum[SumW-1:FracW]);

  always_comb begin
    if (rnd_q > signed'(RoundW'(hfci_pkg::HeightMax))) begin
      height_d = signed'(HeightW'(hfci_pkg::HeightMax));
    end else if (rnd_q < signed'(RoundW'(hfci_pkg::HeightMin))) begin
      height_d = signed'(HeightW'(hfci_pkg::HeightMin));
    end else begin
      height_d = HeightW'(rnd_q);
    end
  end

  assign out_data_d.found      = s4_found_q;
  assign out_data_d.height_out = height_d;

  // ---------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_load || (s1_v_q && !move_1);
      s2_v_q  <= move_1q || (s2_v_q && !move_2);
      s3_v_q  <= move_2 || (s3_v_q && !move_3);
      s4_v_q  <= move_3 || (s4_v_q && !move_4);
      out_v_q <= move_4 || (out_v_q && !out_ready_i);
      if (ram_we) begin
        fwd_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_wr_q   <= (in_data_i.op == hfci_pkg::OP_WRITE);
      s1_row_q  <= rd_addr_a;
      s1_lane_q <= LaneW'(dec_lane);
      s1_wval_q <= in_data_i.write_value;
      s1_col_q  <= q_col;
      s1_fr_q   <= in_data_i.frac_row;
      s1_fc_q   <= in_data_i.frac_col;
    end
    if (ram_we) begin
      fwd_row_q  <= s1_row_q;
      fwd_word_q <= row_merged;
    end
    if (move_1q) begin
      s2_found_q <= s1_found;
      s2_ha_q    <= h_c;
      s2_hb_q    <= s1_hb;
      s2_hc_q    <= s1_hc;
      s2_wa_q    <= s1_wa;
      s2_wb_q    <= s1_wb;
      s2_wc_q    <= s1_wc;
    end
    if (move_2) begin
      s3_found_q <= s2_found_q;
      s3_pa_q    <= s3_pa_d;
      s3_pb_q    <= s3_pb_d;
      s3_pc_q    <= s3_pc_d;
    end
    if (move_3) begin
      s4_found_q <= s3_found_q;
      s4_sum_q   <= s4_sum_d;
    end
    if (move_4) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------- assertions
  // Fractions stay below one, so some triangle always holds the point.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> s2_found_q)
    else $error("query reached multiply stage without a containing triangle");

  // Selected weights partition the common denominator.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_found_q) |->
      ((int'(s2_wa_q) + int'(s2_wb_q) + int'(s2_wc_q)) == int'(hfci_pkg::FracOne)))
    else $error("barycentric weights do not sum to one");

  // A write occupies stage 1 for one cycle only.
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_wr_q) |=> (!(s1_v_q && s1_wr_q) || $past(s1_load)))
    else $error("grid write held in stage 1");

  // Input stalls only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_v_q && s2_v_q && s3_v_q && s4_v_q && out_v_q))
    else $error("input stalled while a stage was free");

endmodule
`default_nettype wire
